### rtl/cfw_pkg.sv
// Shared types, widths and constants for the cartesian to fractional converter.
`timescale 1ns / 1ps

package cfw_pkg;

    localparam int COORD_W         = 32;  // cartesian input, signed Q16.16
    localparam int FRAC_W          = 32;  // fractional output, signed Q8.24
    localparam int INV_W           = 32;  // reciprocal length, unsigned Q4.28
    localparam int COMP_W          = 21;  // reciprocal vector component, signed Q1.20
    localparam int ROW_W           = 3 * COMP_W;
    localparam int LANES           = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // 1/sqrt3 and 2/sqrt3 in unsigned Q2.30, held as positive signed words
    localparam logic signed [COORD_W-1:0] K_INV_SQRT3 = 32'sd619925131;
    localparam logic signed [COORD_W-1:0] K_TWO_SQRT3 = 32'sd1239850262;

    localparam int FRAC_LOG2 = 24;  // 1.0 in Q8.24
    localparam int CAP_LOG2  = 40;  // magnitude limit of a scaled product

    typedef enum logic [1:0] {
        MODE_HEX     = 2'd0,
        MODE_CUBIC   = 2'd1,
        MODE_ORTHO   = 2'd2,
        MODE_GENERAL = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LATTICE_MODE = 3'd0,
        REG_INV_LEN_A    = 3'd1,
        REG_INV_LEN_B    = 3'd2,
        REG_INV_LEN_C    = 3'd3,
        REG_RECIP_ROW_X  = 3'd4,
        REG_RECIP_ROW_Y  = 3'd5,
        REG_RECIP_ROW_Z  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        mode_t              lattice_mode;
        logic [INV_W-1:0]   inv_len_a;
        logic [INV_W-1:0]   inv_len_b;
        logic [INV_W-1:0]   inv_len_c;
        logic [ROW_W-1:0]   recip_row_x;
        logic [ROW_W-1:0]   recip_row_y;
        logic [ROW_W-1:0]   recip_row_z;
    } cfg_t;

    // One classified position: coordinates, mode and the reciprocal per lane
    typedef struct packed {
        logic [COORD_W-1:0]            x;
        logic [COORD_W-1:0]            y;
        logic [COORD_W-1:0]            z;
        mode_t                         mode;
        logic [LANES-1:0][INV_W-1:0]   inv;
    } work_t;

endpackage

### rtl/cfw_if.sv
// Stream and configuration interfaces of the converter.
`timescale 1ns / 1ps

interface cfw_cart_if;
    logic                          valid;
    logic                          ready;
    logic signed [cfw_pkg::COORD_W-1:0] cart_x;
    logic signed [cfw_pkg::COORD_W-1:0] cart_y;
    logic signed [cfw_pkg::COORD_W-1:0] cart_z;

    modport source (output valid, output cart_x, output cart_y, output cart_z, input ready);
    modport sink   (input valid, input cart_x, input cart_y, input cart_z, output ready);
endinterface

interface cfw_frac_if;
    logic                          valid;
    logic                          ready;
    logic signed [cfw_pkg::FRAC_W-1:0] frac_x;
    logic signed [cfw_pkg::FRAC_W-1:0] frac_y;
    logic signed [cfw_pkg::FRAC_W-1:0] frac_z;
    logic                          saturated;

    modport source (output valid, output frac_x, output frac_y, output frac_z,
                    output saturated, input ready);
    modport sink   (input valid, input frac_x, input frac_y, input frac_z,
                    input saturated, output ready);
endinterface

interface cfw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cfw_pkg::CFG_IDX_W-1:0]     index;
    logic [cfw_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cfw_front.sv
// Front end: accepts positions and tags each with its mode and per-lane reciprocal.
`timescale 1ns / 1ps

module cfw_front (
    input  logic             clk,
    input  logic             rst_n,
    cfw_cart_if.sink         cart,
    input  cfw_pkg::cfg_t    cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output cfw_pkg::work_t   out_data
);
    import cfw_pkg::*;

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;

    always_comb
    begin
        work_next.x    = cart.cart_x;
        work_next.y    = cart.cart_y;
        work_next.z    = cart.cart_z;
        work_next.mode = cfg.lattice_mode;
        unique case (cfg.lattice_mode)
            MODE_HEX:
            begin
                work_next.inv[0] = cfg.inv_len_a;
                work_next.inv[1] = cfg.inv_len_a;
                work_next.inv[2] = cfg.inv_len_c;
            end
            MODE_CUBIC:
            begin
                work_next.inv[0] = cfg.inv_len_a;
                work_next.inv[1] = cfg.inv_len_a;
                work_next.inv[2] = cfg.inv_len_a;
            end
            MODE_ORTHO:
            begin
                work_next.inv[0] = cfg.inv_len_a;
                work_next.inv[1] = cfg.inv_len_b;
                work_next.inv[2] = cfg.inv_len_c;
            end
            default:
            begin
                // general matrix mode does not scale by lengths
                work_next.inv = '0;
            end
        endcase
    end

    assign cart.ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cart.ready)
        begin
            valid_reg <= cart.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cart.ready && cart.valid)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = work_reg;

endmodule

### rtl/cfw_queue.sv
// Short FIFO that decouples the front end from the arithmetic pipeline.
`timescale 1ns / 1ps

module cfw_queue #(
    parameter int DEPTH = cfw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  cfw_pkg::work_t   push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cfw_pkg::work_t   pop_data
);
    import cfw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

### rtl/cfw_back.sv
// Back end: six-stage multiply, round, scale, wrap and clamp pipeline.
`timescale 1ns / 1ps

module cfw_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cfw_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  cfw_pkg::work_t   in_data,
    cfw_frac_if.source       frac
);
    import cfw_pkg::*;

    localparam int STAGES      = 6;
    localparam int GP_W        = COORD_W + COMP_W;      // one matrix product
    localparam int ACC_W       = GP_W + 2;              // sum of three
    localparam int HP_W        = 2 * COORD_W;           // hexagonal products
    localparam int GEN_SHIFT   = 12;
    localparam int HEX_SHIFT   = 30;
    localparam int SCALE_SHIFT = 20;
    localparam int Q_W         = HP_W - HEX_SHIFT;      // Q.16 operand of scaling
    localparam int P_W         = Q_W + INV_W + 1;
    localparam int R_W         = P_W - SCALE_SHIFT;
    localparam int V_W         = ACC_W - GEN_SHIFT;     // Q.24 before clamp

    localparam logic [ACC_W-1:0] GEN_HALF   = ACC_W'(64'd1 << (GEN_SHIFT - 1));
    localparam logic [HP_W-1:0]  HEX_HALF   = HP_W'(64'd1 << (HEX_SHIFT - 1));
    localparam logic [P_W-1:0]   SCALE_HALF = P_W'(64'd1 << (SCALE_SHIFT - 1));
    localparam logic signed [R_W-1:0] CAP_POS = R_W'(64'd1 << CAP_LOG2);
    localparam logic signed [R_W-1:0] CAP_NEG = -CAP_POS;
    localparam logic signed [V_W-1:0] FRAC_ONE = V_W'(64'd1 << FRAC_LOG2);
    localparam logic signed [V_W-1:0] OUT_MAX =
        $signed({{(V_W - FRAC_W + 1){1'b0}}, {(FRAC_W - 1){1'b1}}});
    localparam logic signed [V_W-1:0] OUT_MIN =
        $signed({{(V_W - FRAC_W + 1){1'b1}}, {(FRAC_W - 1){1'b0}}});
    localparam logic [FRAC_W-1:0] FRAC_MAX = {1'b0, {(FRAC_W - 1){1'b1}}};
    localparam logic [FRAC_W-1:0] FRAC_MIN = {1'b1, {(FRAC_W - 1){1'b0}}};

    logic [STAGES-1:0] stage_valid_reg;
    logic [STAGES-1:0] stage_en;

    // stage 1: products
    mode_t                     s1_mode_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [INV_W-1:0]          s1_inv_reg [LANES];
    logic signed [HP_W-1:0]    s1_py1_reg, s1_py2_reg;
    logic signed [GP_W-1:0]    s1_gp_reg [LANES][3];
    // stage 2: sums
    mode_t                     s2_mode_reg;
    logic signed [COORD_W-1:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic [INV_W-1:0]          s2_inv_reg [LANES];
    logic signed [HP_W-1:0]    s2_u_reg, s2_w_reg;
    logic signed [ACC_W-1:0]   s2_acc_reg [LANES];
    // stage 3: rounded operands
    mode_t                     s3_mode_reg;
    logic signed [Q_W-1:0]     s3_q_reg [LANES];
    logic [INV_W-1:0]          s3_inv_reg [LANES];
    logic signed [V_W-1:0]     s3_f_reg [LANES];
    // stage 4: scaled products
    mode_t                     s4_mode_reg;
    logic signed [P_W-1:0]     s4_p_reg [LANES];
    logic signed [V_W-1:0]     s4_f_reg [LANES];
    // stage 5: Q.24 values
    logic                      s5_wrap_reg;
    logic signed [V_W-1:0]     s5_v_reg [LANES];
    // stage 6: output
    logic [FRAC_W-1:0]         out_frac_reg [LANES];
    logic                      out_sat_reg;

    // combinational values of each stage
    logic signed [COORD_W-1:0] in_x, in_y, in_z;
    logic signed [GP_W-1:0]    gp_c [LANES][3];
    logic signed [HP_W-1:0]    x_shift;
    logic [ACC_W-1:0]          acc_rnd [LANES];
    logic [HP_W-1:0]           u_rnd, w_rnd;
    logic signed [Q_W-1:0]     q_c [LANES];
    logic [P_W-1:0]            p_rnd [LANES];
    logic signed [R_W-1:0]     r_c [LANES];
    logic signed [V_W-1:0]     v_c [LANES];
    logic signed [V_W-1:0]     wv_c [LANES];
    logic [FRAC_W-1:0]         o_c [LANES];
    logic [LANES-1:0]          sat_c;

    always_comb
    begin
        stage_en[STAGES-1] = !stage_valid_reg[STAGES-1] || frac.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !stage_valid_reg[k] || stage_en[k+1];
        end
    end

    assign in_ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                stage_valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    stage_valid_reg[k] <= stage_valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: matrix products and the two hexagonal y terms
    assign in_x = $signed(in_data.x);
    assign in_y = $signed(in_data.y);
    assign in_z = $signed(in_data.z);

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            gp_c[j][0] = in_x * $signed(cfg.recip_row_x[COMP_W*j +: COMP_W]);
            gp_c[j][1] = in_y * $signed(cfg.recip_row_y[COMP_W*j +: COMP_W]);
            gp_c[j][2] = in_z * $signed(cfg.recip_row_z[COMP_W*j +: COMP_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_mode_reg <= in_data.mode;
            s1_x_reg    <= in_x;
            s1_y_reg    <= in_y;
            s1_z_reg    <= in_z;
            s1_py1_reg  <= in_y * K_INV_SQRT3;
            s1_py2_reg  <= in_y * K_TWO_SQRT3;
            for (int j = 0; j < LANES; j++)
            begin
                s1_inv_reg[j] <= in_data.inv[j];
                for (int t = 0; t < 3; t++)
                begin
                    s1_gp_reg[j][t] <= gp_c[j][t];
                end
            end
        end
    end

    // stage 2: matrix sums, x - y/sqrt3
    assign x_shift = {{(HP_W - COORD_W - HEX_SHIFT){s1_x_reg[COORD_W-1]}}, s1_x_reg,
                      {HEX_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_z_reg    <= s1_z_reg;
            s2_u_reg    <= x_shift - s1_py1_reg;
            s2_w_reg    <= s1_py2_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s2_inv_reg[j] <= s1_inv_reg[j];
                s2_acc_reg[j] <= ACC_W'(s1_gp_reg[j][0]) + ACC_W'(s1_gp_reg[j][1])
                               + ACC_W'(s1_gp_reg[j][2]);
            end
        end
    end

    // stage 3: round to nearest, ties away from zero: (v + half - neg) >> s
    always_comb
    begin
        u_rnd = s2_u_reg + HEX_HALF - HP_W'(s2_u_reg[HP_W-1]);
        w_rnd = s2_w_reg + HEX_HALF - HP_W'(s2_w_reg[HP_W-1]);
        for (int j = 0; j < LANES; j++)
        begin
            acc_rnd[j] = s2_acc_reg[j] + GEN_HALF - ACC_W'(s2_acc_reg[j][ACC_W-1]);
        end
        if (s2_mode_reg == MODE_HEX)
        begin
            q_c[0] = $signed(u_rnd[HP_W-1:HEX_SHIFT]);
            q_c[1] = $signed(w_rnd[HP_W-1:HEX_SHIFT]);
        end
        else
        begin
            q_c[0] = Q_W'(s2_x_reg);
            q_c[1] = Q_W'(s2_y_reg);
        end
        q_c[2] = Q_W'(s2_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_mode_reg <= s2_mode_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s3_q_reg[j]   <= q_c[j];
                s3_inv_reg[j] <= s2_inv_reg[j];
                s3_f_reg[j]   <= $signed(acc_rnd[j][ACC_W-1:GEN_SHIFT]);
            end
        end
    end

    // stage 4: Q.16 times Q4.28 reciprocal
    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_mode_reg <= s3_mode_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s4_p_reg[j] <= s3_q_reg[j] * $signed({1'b0, s3_inv_reg[j]});
                s4_f_reg[j] <= s3_f_reg[j];
            end
        end
    end

    // stage 5: round the product to Q.24 and cap its magnitude; general mode passes the matrix sum instead
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            p_rnd[j] = s4_p_reg[j] + SCALE_HALF - P_W'(s4_p_reg[j][P_W-1]);
            r_c[j]   = $signed(p_rnd[j][P_W-1:SCALE_SHIFT]);
            if (s4_mode_reg == MODE_GENERAL)
            begin
                v_c[j] = s4_f_reg[j];
            end
            else if (r_c[j] > CAP_POS)
            begin
                v_c[j] = V_W'(CAP_POS);
            end
            else if (r_c[j] < CAP_NEG)
            begin
                v_c[j] = V_W'(CAP_NEG);
            end
            else
            begin
                v_c[j] = V_W'(r_c[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_wrap_reg <= (s4_mode_reg != MODE_GENERAL);
            for (int j = 0; j < LANES; j++)
            begin
                s5_v_reg[j] <= v_c[j];
            end
        end
    end

    // stage 6: single wrap except in general mode, then clamp to the output range
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (s5_wrap_reg && (s5_v_reg[j] < 0))
            begin
                wv_c[j] = s5_v_reg[j] + FRAC_ONE;
            end
            else if (s5_wrap_reg && (s5_v_reg[j] > FRAC_ONE))
            begin
                wv_c[j] = s5_v_reg[j] - FRAC_ONE;
            end
            else
            begin
                wv_c[j] = s5_v_reg[j];
            end
            if (wv_c[j] > OUT_MAX)
            begin
                o_c[j]   = FRAC_MAX;
                sat_c[j] = 1'b1;
            end
            else if (wv_c[j] < OUT_MIN)
            begin
                o_c[j]   = FRAC_MIN;
                sat_c[j] = 1'b1;
            end
            else
            begin
                o_c[j]   = wv_c[j][FRAC_W-1:0];
                sat_c[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            out_sat_reg <= |sat_c;
            for (int j = 0; j < LANES; j++)
            begin
                out_frac_reg[j] <= o_c[j];
            end
        end
    end

    assign frac.valid     = stage_valid_reg[STAGES-1];
    assign frac.frac_x    = out_frac_reg[0];
    assign frac.frac_y    = out_frac_reg[1];
    assign frac.frac_z    = out_frac_reg[2];
    assign frac.saturated = out_sat_reg;

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (frac.valid && frac.saturated) |->
            (out_frac_reg[0] == FRAC_MAX || out_frac_reg[0] == FRAC_MIN ||
             out_frac_reg[1] == FRAC_MAX || out_frac_reg[1] == FRAC_MIN ||
             out_frac_reg[2] == FRAC_MAX || out_frac_reg[2] == FRAC_MIN))
        else $error("saturated flag with no coordinate at a bound");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg[STAGES-1] && !frac.ready && stage_valid_reg[STAGES-2])
            |=> stage_valid_reg[STAGES-2])
        else $error("pipeline dropped a transaction behind a stalled result");

endmodule

### rtl/cartesian_to_fractional_wrap.sv
// Top level of the cartesian to fractional coordinate converter.
// Converts one signed Q16.16 cartesian position per transaction into signed
// Q8.24 fractional crystal coordinates plus a saturated flag. The lattice_mode
// register picks the conversion: hexagonal (fixed 1/sqrt3 and 2/sqrt3 terms,
// scaled by inv_len_a, z by inv_len_c), cubic (all axes by inv_len_a),
// orthorhombic (a, b, c per axis), each followed by a single wrap into about
// [0, 1]; or general, a product with the three packed reciprocal rows and no
// wrap. Every result is clamped to 32 bits and the flag reports any clamp.
// Throughput is one transaction per clock while frac.ready is high; each lane
// has its own 34 x 33 scaling multiplier and three 32 x 21 matrix
// multipliers, all pipelined. A transaction passes the front register, the
// queue and six arithmetic stages. Configuration writes are accepted at
// any time (cfg.ready is always high) but must only be issued while no
// transaction is in flight; indexes beyond the register list are ignored.
// There is no post-reset initialization sequence.
`timescale 1ns / 1ps

module cartesian_to_fractional_wrap #(
    parameter int QUEUE_DEPTH = cfw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cfw_cart_if.sink    cart,
    cfw_frac_if.source  frac,
    cfw_cfg_if.sink     cfg
);
    import cfw_pkg::*;

    cfg_t  cfg_reg;
    logic  fq_valid;
    logic  fq_ready;
    work_t fq_data;
    logic  qb_valid;
    logic  qb_ready;
    work_t qb_data;

    // register file; bits above each register's width are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lattice_mode <= MODE_GENERAL;
            cfg_reg.inv_len_a    <= '0;
            cfg_reg.inv_len_b    <= '0;
            cfg_reg.inv_len_c    <= '0;
            cfg_reg.recip_row_x  <= '0;
            cfg_reg.recip_row_y  <= '0;
            cfg_reg.recip_row_z  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_LATTICE_MODE: cfg_reg.lattice_mode <= mode_t'(cfg.data[1:0]);
                REG_INV_LEN_A:    cfg_reg.inv_len_a    <= cfg.data[INV_W-1:0];
                REG_INV_LEN_B:    cfg_reg.inv_len_b    <= cfg.data[INV_W-1:0];
                REG_INV_LEN_C:    cfg_reg.inv_len_c    <= cfg.data[INV_W-1:0];
                REG_RECIP_ROW_X:  cfg_reg.recip_row_x  <= cfg.data[ROW_W-1:0];
                REG_RECIP_ROW_Y:  cfg_reg.recip_row_y  <= cfg.data[ROW_W-1:0];
                REG_RECIP_ROW_Z:  cfg_reg.recip_row_z  <= cfg.data[ROW_W-1:0];
                default:          ;  // unmapped index: write dropped
            endcase
        end
    end

    // front: accept and classify
    cfw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cart      (cart),
        .cfg       (cfg_reg),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_data  (fq_data)
    );

    // decoupling queue
    cfw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // back: arithmetic pipeline and output register
    cfw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_data  (qb_data),
        .frac     (frac)
    );

endmodule
